### sv/mtrh_pkg.sv
// Shared types and constants for the Modbus TCP request handler.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package mtrh_pkg;

    typedef struct packed {
        logic        operation;
        logic [7:0]  rx_byte;
        logic [15:0] load_address;
        logic [15:0] load_value;
    } in_item_t;

    typedef struct packed {
        logic [63:0] resp_bytes;
        logic [3:0]  resp_count;
        logic        resp_last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_DISPATCH,
        ST_WR_A,
        ST_WR_B,
        ST_WR_C,
        ST_EMIT_FIX,
        ST_RD_ADDR,
        ST_RD_HI,
        ST_RD_LO
    } state_t;

    typedef enum logic [1:0] {
        OUTC_READ,
        OUTC_WRITE1,
        OUTC_WRITEN,
        OUTC_EXC
    } outcome_t;

    typedef struct packed {
        logic clear_step;
        logic take_item;
        logic decide;
        logic write_one;
        logic wr_hi;
        logic wr_lo;
        logic wr_commit;
        logic emit_fix;
        logic rd_issue;
        logic emit_hi;
        logic emit_lo;
    } cmd_t;

    typedef struct packed {
        logic     clear_last;
        logic     frame_end;
        outcome_t outcome;
        logic     word_last;
        logic     fix_end;
        logic     emit_ok;
    } status_t;

    localparam logic [1:0] CFG_UNIT_ID    = 2'd0;
    localparam logic [1:0] CFG_WRITE_LOW  = 2'd1;
    localparam logic [1:0] CFG_WRITE_HIGH = 2'd2;

    localparam logic [7:0] FC_READ_HOLD  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT = 8'd4;
    localparam logic [7:0] FC_WRITE_ONE  = 8'd6;
    localparam logic [7:0] FC_WRITE_MANY = 8'd16;

    localparam logic [7:0] EXC_FUNCTION = 8'd1;
    localparam logic [7:0] EXC_ADDRESS  = 8'd2;
    localparam logic [7:0] EXC_VALUE    = 8'd3;

    localparam logic [7:0] UNIT_BROADCAST = 8'hFF;
    localparam logic [7:0] EXC_FLAG       = 8'h80;
    localparam logic [15:0] LEN_MIN       = 16'd2;
    localparam logic [15:0] LEN_MAX       = 16'd253;
    localparam logic [15:0] READ_QTY_MAX  = 16'd125;
    localparam logic [15:0] WRITE_QTY_MAX = 16'd123;
    localparam logic [16:0] ADDR_SPAN     = 17'h10000;

endpackage

`default_nettype wire

### sv/mtrh_ctrl.sv
// Controller state machine of the Modbus TCP request handler.
// Depends on mtrh_pkg; drives commands to mtrh_dp and reads its status.
`default_nettype none

module mtrh_ctrl
    import mtrh_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t sts,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    if (sts.frame_end)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                unique case (sts.outcome)
                    OUTC_WRITE1:
                    begin
                        cmd.write_one = 1'b1;
                        state_next    = ST_EMIT_FIX;
                    end
                    OUTC_WRITEN: state_next = ST_WR_A;
                    default:     state_next = ST_EMIT_FIX;
                endcase
            end
            ST_WR_A:
            begin
                cmd.wr_hi  = 1'b1;
                state_next = ST_WR_B;
            end
            ST_WR_B:
            begin
                cmd.wr_lo  = 1'b1;
                state_next = ST_WR_C;
            end
            ST_WR_C:
            begin
                cmd.wr_commit = 1'b1;
                state_next    = sts.word_last ? ST_EMIT_FIX : ST_WR_A;
            end
            ST_EMIT_FIX:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit_fix = 1'b1;
                    if (sts.fix_end)
                    begin
                        state_next = (sts.outcome == OUTC_READ) ? ST_RD_ADDR : ST_IDLE;
                    end
                end
            end
            ST_RD_ADDR:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit_hi = 1'b1;
                    state_next  = ST_RD_LO;
                end
            end
            ST_RD_LO:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit_lo = 1'b1;
                    state_next  = sts.word_last ? ST_IDLE : ST_RD_ADDR;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### sv/mtrh_dp.sv
// Datapath of the Modbus TCP request handler: parser, stores, checks and packer.
// Depends on mtrh_pkg; sequenced by mtrh_ctrl through command and status structs.
`default_nettype none

module mtrh_dp
    import mtrh_pkg::*;
#(
    parameter int HOLD_DEPTH  = 256,
    parameter int INPUT_DEPTH = 256
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_t      cmd,
    output status_t        sts,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data,
    input  wire logic      cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int HAW  = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int IAW  = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
    localparam int MAXD = (HOLD_DEPTH > INPUT_DEPTH) ? HOLD_DEPTH : INPUT_DEPTH;

    logic [7:0]  unit_id_reg;
    logic [15:0] write_low_reg;
    logic [15:0] write_high_reg;

    logic        phase_reg;
    logic [7:0]  pos_reg;
    logic [7:0]  hdr_reg [0:6];
    logic [7:0]  cap_reg [0:5];
    logic [7:0]  rs_mem  [0:255];
    logic [7:0]  rs_rdata_reg;
    logic [7:0]  hi_reg;

    logic [15:0] hold_mem [0:HOLD_DEPTH-1];
    logic [15:0] meas_mem [0:INPUT_DEPTH-1];
    logic [15:0] hold_rdata_reg;
    logic [15:0] meas_rdata_reg;
    logic        hold_ok_reg;
    logic        meas_ok_reg;

    logic [16:0] clr_reg;

    outcome_t    outcome_reg;
    outcome_t    outcome_next;
    logic [7:0]  exc_reg;
    logic [7:0]  exc_next;
    logic [7:0]  n_reg;
    logic [7:0]  n_next;
    logic [6:0]  widx_reg;
    logic [8:0]  bidx_reg;

    logic [63:0] acc_reg;
    logic [3:0]  cnt_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic [7:0]  plen;
    logic [15:0] hlen;
    logic [15:0] addr_a;
    logic [15:0] qty;
    logic [7:0]  fc;
    logic [7:0]  bc;
    logic [16:0] span_end;
    logic [16:0] last_addr;
    logic [16:0] word_addr;
    logic [7:0]  rs_raddr;
    logic        take_byte;
    logic        header_ok;
    logic        emit;
    logic [7:0]  emit_byte;
    logic [7:0]  fix_byte;
    logic [15:0] rd_word;
    logic        byte_last;
    logic [63:0] acc_new;
    logic        hold_we;
    logic [16:0] hold_waddr;
    logic [15:0] hold_wdata;
    logic        meas_we;
    logic [16:0] meas_waddr;
    logic [15:0] meas_wdata;

    assign hlen      = {hdr_reg[4], hdr_reg[5]};
    assign plen      = hdr_reg[5] - 8'd1;
    assign fc        = cap_reg[0];
    assign addr_a    = {cap_reg[1], cap_reg[2]};
    assign qty       = {cap_reg[3], cap_reg[4]};
    assign bc        = cap_reg[5];
    assign span_end  = {1'b0, addr_a} + {1'b0, qty};
    assign last_addr = span_end - 17'd1;
    assign word_addr = {1'b0, addr_a} + {10'd0, widx_reg};
    assign take_byte = cmd.take_item && !in_data.operation;
    assign header_ok = (hdr_reg[2] == 8'd0) && (hdr_reg[3] == 8'd0)
                       && (hlen >= LEN_MIN) && (hlen <= LEN_MAX)
                       && ((in_data.rx_byte == unit_id_reg)
                           || (in_data.rx_byte == UNIT_BROADCAST));
    assign rs_raddr  = (cmd.wr_lo ? 8'd7 : 8'd6) + {widx_reg, 1'b0};
    assign byte_last = (bidx_reg == ({1'b0, n_reg} + 9'd6));
    assign emit      = cmd.emit_fix || cmd.emit_hi || cmd.emit_lo;
    assign rd_word   = (fc == FC_READ_INPUT) ? (meas_ok_reg ? meas_rdata_reg : 16'd0)
                                             : (hold_ok_reg ? hold_rdata_reg : 16'd0);

    always_comb
    begin
        sts.clear_last = (clr_reg == 17'(MAXD - 1));
        sts.frame_end  = phase_reg && !in_data.operation && ((pos_reg + 8'd1) == plen);
        sts.outcome    = outcome_reg;
        sts.word_last  = ({9'd0, widx_reg} == (qty - 16'd1));
        sts.fix_end    = (outcome_reg == OUTC_READ) ? (bidx_reg == 9'd8) : byte_last;
        sts.emit_ok    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        outcome_next = OUTC_EXC;
        exc_next     = EXC_FUNCTION;
        n_next       = 8'd2;
        if ((fc == FC_READ_HOLD) || (fc == FC_READ_INPUT))
        begin
            if ((plen != 8'd5) || (qty == 16'd0) || (qty > READ_QTY_MAX))
            begin
                exc_next = EXC_VALUE;
            end
            else if (span_end > ADDR_SPAN)
            begin
                exc_next = EXC_ADDRESS;
            end
            else
            begin
                outcome_next = OUTC_READ;
                n_next       = 8'd2 + {qty[6:0], 1'b0};
            end
        end
        else if (fc == FC_WRITE_ONE)
        begin
            if (plen != 8'd5)
            begin
                exc_next = EXC_VALUE;
            end
            else if ((addr_a < write_low_reg) || (addr_a > write_high_reg))
            begin
                exc_next = EXC_ADDRESS;
            end
            else
            begin
                outcome_next = OUTC_WRITE1;
                n_next       = 8'd5;
            end
        end
        else if (fc == FC_WRITE_MANY)
        begin
            if ((plen < 8'd6) || ({1'b0, plen} != ({1'b0, bc} + 9'd6))
                || (qty == 16'd0) || (qty > WRITE_QTY_MAX)
                || ({9'd0, bc} != {qty, 1'b0}))
            begin
                exc_next = EXC_VALUE;
            end
            else if ((span_end > ADDR_SPAN) || (addr_a < write_low_reg)
                     || (last_addr > {1'b0, write_high_reg}))
            begin
                exc_next = EXC_ADDRESS;
            end
            else
            begin
                outcome_next = OUTC_WRITEN;
                n_next       = 8'd5;
            end
        end
    end

    always_comb
    begin
        fix_byte = 8'd0;
        unique case (bidx_reg[3:0])
            4'd0:    fix_byte = hdr_reg[0];
            4'd1:    fix_byte = hdr_reg[1];
            4'd5:    fix_byte = n_reg + 8'd1;
            4'd6:    fix_byte = hdr_reg[6];
            4'd7:    fix_byte = (outcome_reg == OUTC_EXC) ? (fc | EXC_FLAG) : fc;
            4'd8:
            begin
                unique case (outcome_reg)
                    OUTC_READ: fix_byte = {qty[6:0], 1'b0};
                    OUTC_EXC:  fix_byte = exc_reg;
                    default:   fix_byte = cap_reg[1];
                endcase
            end
            4'd9:    fix_byte = cap_reg[2];
            4'd10:   fix_byte = cap_reg[3];
            4'd11:   fix_byte = cap_reg[4];
            default: fix_byte = 8'd0;
        endcase
        if (cmd.emit_hi)
        begin
            emit_byte = rd_word[15:8];
        end
        else if (cmd.emit_lo)
        begin
            emit_byte = rd_word[7:0];
        end
        else
        begin
            emit_byte = fix_byte;
        end
    end

    always_comb
    begin
        acc_new = acc_reg;
        for (int k = 0; k < 8; k++)
        begin
            if (cnt_reg == 4'(k))
            begin
                acc_new[63 - 8*k -: 8] = emit_byte;
            end
        end
    end

    always_comb
    begin
        hold_we    = 1'b0;
        hold_waddr = word_addr;
        hold_wdata = {hi_reg, rs_rdata_reg};
        if (cmd.clear_step)
        begin
            hold_we    = 1'b1;
            hold_waddr = clr_reg;
            hold_wdata = 16'd0;
        end
        else if (cmd.write_one)
        begin
            hold_we    = 1'b1;
            hold_waddr = {1'b0, addr_a};
            hold_wdata = qty;
        end
        else if (cmd.wr_commit)
        begin
            hold_we = 1'b1;
        end
        meas_we    = 1'b0;
        meas_waddr = {1'b0, in_data.load_address};
        meas_wdata = in_data.load_value;
        if (cmd.clear_step)
        begin
            meas_we    = 1'b1;
            meas_waddr = clr_reg;
            meas_wdata = 16'd0;
        end
        else if (cmd.take_item && in_data.operation)
        begin
            meas_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_we && (hold_waddr < 17'(HOLD_DEPTH)))
        begin
            hold_mem[hold_waddr[HAW-1:0]] <= hold_wdata;
        end
        if (meas_we && (meas_waddr < 17'(INPUT_DEPTH)))
        begin
            meas_mem[meas_waddr[IAW-1:0]] <= meas_wdata;
        end
        if (cmd.rd_issue)
        begin
            hold_rdata_reg <= hold_mem[word_addr[HAW-1:0]];
            meas_rdata_reg <= meas_mem[word_addr[IAW-1:0]];
            hold_ok_reg    <= (word_addr < 17'(HOLD_DEPTH));
            meas_ok_reg    <= (word_addr < 17'(INPUT_DEPTH));
        end
        if (take_byte && phase_reg)
        begin
            rs_mem[pos_reg] <= in_data.rx_byte;
        end
        if (cmd.wr_hi || cmd.wr_lo)
        begin
            rs_rdata_reg <= rs_mem[rs_raddr];
        end
        if (cmd.wr_lo)
        begin
            hi_reg <= rs_rdata_reg;
        end
        if (take_byte)
        begin
            if (!phase_reg)
            begin
                hdr_reg[pos_reg[2:0]] <= in_data.rx_byte;
            end
            else if (pos_reg < 8'd6)
            begin
                cap_reg[pos_reg[2:0]] <= in_data.rx_byte;
            end
        end
        if (cmd.decide)
        begin
            exc_reg <= exc_next;
            n_reg   <= n_next;
        end
        if (emit && ((cnt_reg == 4'd7) || byte_last))
        begin
            out_reg.resp_bytes <= acc_new;
            out_reg.resp_count <= cnt_reg + 4'd1;
            out_reg.resp_last  <= byte_last;
        end
        if (emit)
        begin
            acc_reg <= ((cnt_reg == 4'd7) || byte_last) ? 64'd0 : acc_new;
        end
        if (cmd.decide)
        begin
            acc_reg <= 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_id_reg    <= 8'd1;
            write_low_reg  <= 16'd0;
            write_high_reg <= 16'hFFFF;
            phase_reg      <= 1'b0;
            pos_reg        <= 8'd0;
            clr_reg        <= 17'd0;
            outcome_reg    <= OUTC_EXC;
            widx_reg       <= 7'd0;
            bidx_reg       <= 9'd0;
            cnt_reg        <= 4'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_UNIT_ID:    unit_id_reg    <= cfg_data[7:0];
                    CFG_WRITE_LOW:  write_low_reg  <= cfg_data;
                    CFG_WRITE_HIGH: write_high_reg <= cfg_data;
                    default:        unit_id_reg    <= unit_id_reg;
                endcase
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 17'd1;
            end
            if (take_byte)
            begin
                if (!phase_reg)
                begin
                    if (pos_reg == 8'd6)
                    begin
                        pos_reg   <= 8'd0;
                        phase_reg <= header_ok;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 8'd1;
                    end
                end
                else if (sts.frame_end)
                begin
                    pos_reg   <= 8'd0;
                    phase_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_reg + 8'd1;
                end
            end
            if (cmd.decide)
            begin
                outcome_reg <= outcome_next;
                widx_reg    <= 7'd0;
                bidx_reg    <= 9'd0;
                cnt_reg     <= 4'd0;
            end
            if (cmd.wr_commit)
            begin
                widx_reg <= sts.word_last ? 7'd0 : widx_reg + 7'd1;
            end
            if (cmd.emit_lo)
            begin
                widx_reg <= widx_reg + 7'd1;
            end
            if (emit)
            begin
                bidx_reg <= bidx_reg + 9'd1;
                cnt_reg  <= ((cnt_reg == 4'd7) || byte_last) ? 4'd0 : cnt_reg + 4'd1;
            end
            if (emit && ((cnt_reg == 4'd7) || byte_last))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### sv/modbus_tcp_request_handler_core.sv
// Top level of the Modbus TCP request handler.
// Depends on mtrh_pkg, mtrh_ctrl and mtrh_dp.
//
// The block takes the received request stream one byte per item, or an
// input-register load word, and answers each complete request that passes
// the header checks with a response frame in chunks of up to eight bytes.
// Bytes and loads are accepted back to back while a request is collected.
// After the last request byte no item is accepted until the response has
// been emitted: the request is checked in ST_DECIDE and ST_DISPATCH, the
// fixed response bytes are sent (nine for reads and exceptions, twelve for
// write echoes), and each word passes through ST_WR_A, ST_WR_B and ST_WR_C
// for function 16 or ST_RD_ADDR, ST_RD_HI and ST_RD_LO for functions 3 and 4,
// since the controller walks one stored word at a time through the single
// read port of each memory. Emission also pauses while a finished chunk waits
// on out_ready. After reset, a clearing pass over max(HOLD_DEPTH, INPUT_DEPTH)
// addresses zeroes both word stores, and no item is accepted during it.
`default_nettype none

module modbus_tcp_request_handler_core
    import mtrh_pkg::*;
#(
    parameter int HOLD_DEPTH  = 256,
    parameter int INPUT_DEPTH = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cmd_t    cmd;
    status_t sts;

    mtrh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mtrh_dp #(
        .HOLD_DEPTH  (HOLD_DEPTH),
        .INPUT_DEPTH (INPUT_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

### sim/tb_modbus_tcp_request_handler_core.sv
// Self-checking testbench for the Modbus TCP request handler core.
// Depends on mtrh_pkg and modbus_tcp_request_handler_core; it streams request bytes and
// input-register loads and compares every response chunk with a built-in predictor.
`default_nettype none

module tb_modbus_tcp_request_handler_core;
    import mtrh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_UNIT_ID;
    logic [15:0] cfg_data = '0;

    modbus_tcp_request_handler_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Predictor state.
    logic [7:0]  unit_sel;
    logic [15:0] win_lo;
    logic [15:0] win_hi;
    logic        in_pdu;
    int unsigned pos_cnt;
    logic [7:0]  hdr_bytes [7];
    logic [7:0]  pdu_bytes [256];
    logic [15:0] hold_mem [256];
    logic [15:0] meas_mem [256];

    out_item_t   chunk_q [$];
    int          errors = 0;
    int          frames = 0;
    int          chunks_seen = 0;
    int          loads = 0;
    bit          quiet = 1'b0;
    int          idle_pct = 13;

    function automatic logic [15:0] pdu_word(int unsigned p);
        return {pdu_bytes[p & 255], pdu_bytes[(p + 1) & 255]};
    endfunction

    function automatic bit writable(int unsigned lo_a, int unsigned hi_a);
        return lo_a >= win_lo && hi_a <= win_hi && lo_a <= hi_a;
    endfunction

    task automatic answer_request(int unsigned plen);
        logic [7:0]  frm [$];
        logic [7:0]  fc;
        logic [7:0]  exc;
        int unsigned a, q, bc, n, cnt;
        logic [15:0] v;
        out_item_t   ch;
        fc = pdu_bytes[0];
        exc = 8'd0;
        frm = {};
        if (fc == FC_READ_HOLD || fc == FC_READ_INPUT)
        begin
            a = pdu_word(1);
            q = pdu_word(3);
            if (plen != 5 || q == 0 || q > READ_QTY_MAX) exc = EXC_VALUE;
            else if (a + q > ADDR_SPAN) exc = EXC_ADDRESS;
            else
            begin
                frm.push_back(fc);
                frm.push_back(8'(q * 2));
                for (int i = 0; i < q; i++)
                begin
                    v = 16'd0;
                    if (a + i < 256) v = (fc == FC_READ_INPUT) ? meas_mem[a + i] : hold_mem[a + i];
                    frm.push_back(v[15:8]);
                    frm.push_back(v[7:0]);
                end
            end
        end
        else if (fc == FC_WRITE_ONE)
        begin
            a = pdu_word(1);
            if (plen != 5) exc = EXC_VALUE;
            else if (!writable(a, a)) exc = EXC_ADDRESS;
            else
            begin
                if (a < 256) hold_mem[a] = pdu_word(3);
                for (int i = 0; i < 5; i++) frm.push_back(pdu_bytes[i]);
            end
        end
        else if (fc == FC_WRITE_MANY)
        begin
            a = pdu_word(1);
            q = pdu_word(3);
            bc = pdu_bytes[5];
            if (plen < 6 || plen != 6 + bc || q == 0 || q > WRITE_QTY_MAX || bc != q * 2)
                exc = EXC_VALUE;
            else if (a + q > ADDR_SPAN || !writable(a, a + q - 1)) exc = EXC_ADDRESS;
            else
            begin
                for (int i = 0; i < q; i++)
                    if (a + i < 256) hold_mem[a + i] = pdu_word(6 + 2 * i);
                for (int i = 0; i < 5; i++) frm.push_back(pdu_bytes[i]);
            end
        end
        else
        begin
            exc = EXC_FUNCTION;
        end
        if (exc != 0)
        begin
            frm.push_back(fc | EXC_FLAG);
            frm.push_back(exc);
        end
        n = frm.size();
        frm.push_front(hdr_bytes[6]);
        frm.push_front(8'(n + 1));
        frm.push_front(8'((n + 1) >> 8));
        frm.push_front(8'd0);
        frm.push_front(8'd0);
        frm.push_front(hdr_bytes[1]);
        frm.push_front(hdr_bytes[0]);
        for (int p = 0; p < frm.size(); p += 8)
        begin
            cnt = (frm.size() - p < 8) ? frm.size() - p : 8;
            ch = '0;
            for (int j = 0; j < cnt; j++) ch.resp_bytes[63 - 8 * j -: 8] = frm[p + j];
            ch.resp_count = 4'(cnt);
            ch.resp_last = (p + cnt >= frm.size());
            chunk_q.push_back(ch);
        end
        frames++;
    endtask

    task automatic predict_item(in_item_t it);
        int unsigned plen;
        if (it.operation)
        begin
            if (it.load_address < 256) meas_mem[it.load_address] = it.load_value;
            loads++;
            return;
        end
        if (!in_pdu)
        begin
            hdr_bytes[pos_cnt] = it.rx_byte;
            pos_cnt++;
            if (pos_cnt < 7) return;
            pos_cnt = 0;
            plen = {hdr_bytes[4], hdr_bytes[5]};
            if (hdr_bytes[2] != 0 || hdr_bytes[3] != 0 || plen < LEN_MIN || plen > LEN_MAX)
                return;
            if (hdr_bytes[6] != unit_sel && hdr_bytes[6] != UNIT_BROADCAST) return;
            in_pdu = 1'b1;
            return;
        end
        pdu_bytes[pos_cnt & 255] = it.rx_byte;
        pos_cnt = (pos_cnt + 1) & 255;
        plen = {hdr_bytes[4], hdr_bytes[5]} - 1;
        if (pos_cnt < plen) return;
        in_pdu = 1'b0;
        pos_cnt = 0;
        answer_request(plen);
    endtask

    // The item stays valid after acceptance until the next call idles or replaces it.
    task automatic send_item(in_item_t it);
        while (!quiet && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(it);
        @(negedge clk);
    endtask

    task automatic send_byte(logic [7:0] b);
        in_item_t it;
        it = '0;
        it.rx_byte = b;
        it.load_address = 16'($urandom);
        it.load_value = 16'($urandom);
        send_item(it);
    endtask

    task automatic send_raw(logic [7:0] raw [$]);
        foreach (raw[i]) send_byte(raw[i]);
    endtask

    task automatic load_word(logic [15:0] adr, logic [15:0] val);
        in_item_t it;
        it.operation = 1'b1;
        it.rx_byte = 8'($urandom);
        it.load_address = adr;
        it.load_value = val;
        send_item(it);
    endtask

    task automatic send_request(logic [7:0] unit, logic [7:0] pdu [$]);
        logic [15:0] len;
        logic [15:0] tid;
        len = 16'(pdu.size() + 1);
        tid = 16'($urandom);
        send_byte(tid[15:8]);
        send_byte(tid[7:0]);
        send_byte(8'd0);
        send_byte(8'd0);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(unit);
        foreach (pdu[i]) send_byte(pdu[i]);
    endtask

    task automatic read_req(logic [7:0] fc, logic [15:0] a, logic [15:0] q);
        send_request(UNIT_BROADCAST, '{fc, a[15:8], a[7:0], q[15:8], q[7:0]});
    endtask

    task automatic write_many_req(logic [15:0] a, int unsigned q);
        logic [7:0] p [$];
        p = '{FC_WRITE_MANY, a[15:8], a[7:0], 8'(q >> 8), 8'(q), 8'(q * 2)};
        for (int i = 0; i < 2 * q; i++) p.push_back(8'($urandom));
        send_request(unit_sel, p);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (chunk_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (500) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [15:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_UNIT_ID: unit_sel = val[7:0];
            CFG_WRITE_LOW: win_lo = val;
            default: win_hi = val;
        endcase
    endtask

    always @(negedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= quiet || ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            chunks_seen++;
            if (chunk_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("Unexpected response chunk %h", out_data);
            end
            else if (out_data !== chunk_q[0])
            begin
                errors++;
                if (errors <= 10)
                    $display("Chunk mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                        chunk_q[0].resp_bytes, chunk_q[0].resp_count, chunk_q[0].resp_last,
                        out_data.resp_bytes, out_data.resp_count, out_data.resp_last);
                void'(chunk_q.pop_front());
            end
            else
            begin
                void'(chunk_q.pop_front());
            end
        end
    end

    task automatic test_directed();
        read_req(FC_READ_HOLD, 16'd0, 16'd2);
        send_request(UNIT_BROADCAST, '{FC_WRITE_ONE, 8'h00, 8'h05, 8'hAB, 8'hCD});
        load_word(16'h0007, 16'hFFFF);
        load_word(16'hFFFF, 16'h5A5A);
        read_req(FC_READ_INPUT, 16'd6, 16'd3);
        read_req(FC_READ_HOLD, 16'd0, 16'd0);
        read_req(FC_READ_HOLD, 16'd0, 16'd126);
        read_req(FC_READ_INPUT, 16'hFFFF, 16'd2);
        read_req(FC_READ_HOLD, 16'hFFFF, 16'd1);
        read_req(FC_READ_HOLD, 16'd0, 16'd125);
        send_request(UNIT_BROADCAST, '{8'h07, 8'h00});
        send_request(UNIT_BROADCAST, '{FC_READ_HOLD, 8'h00, 8'h00, 8'h00});
        write_many_req(16'd250, 8);
        write_many_req(16'hFFFE, 3);
        send_request(UNIT_BROADCAST, '{FC_WRITE_MANY, 8'h00, 8'h00, 8'h00, 8'h01, 8'h04,
                                       8'h11, 8'h22, 8'h33, 8'h44});
        send_request(UNIT_BROADCAST, '{FC_WRITE_MANY, 8'h00});
        send_request(8'h42, '{FC_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h01});
        // A bad protocol id and a bad length must be dropped silently.
        send_raw('{8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h06, 8'h01});
        send_raw('{8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFE, 8'h01});
        read_req(FC_READ_HOLD, 16'd250, 16'd8);
    endtask

    task automatic test_window();
        quiet = 1'b1;
        set_reg(CFG_WRITE_LOW, 16'd10);
        set_reg(CFG_WRITE_HIGH, 16'd20);
        set_reg(CFG_UNIT_ID, 16'd0);
        send_request(8'd0, '{FC_WRITE_ONE, 8'h00, 8'h09, 8'h12, 8'h34});
        send_request(8'd0, '{FC_WRITE_ONE, 8'h00, 8'h0A, 8'h12, 8'h34});
        write_many_req(16'd18, 3);
        write_many_req(16'd18, 3'd3 - 3'd0 - 3'd0 - 3'd1);
        set_reg(CFG_WRITE_LOW, 16'd30);
        send_request(8'd0, '{FC_WRITE_ONE, 8'h00, 8'h1E, 8'h00, 8'h01});
        set_reg(CFG_UNIT_ID, 16'd255);
        set_reg(CFG_WRITE_LOW, 16'd0);
        set_reg(CFG_WRITE_HIGH, 16'hFFFF);
        read_req(FC_READ_HOLD, 16'd8, 16'd16);
        quiet = 1'b0;
    endtask

    task automatic random_requests(int unsigned n_items);
        int unsigned sent;
        int unsigned kind;
        logic [7:0]  p [$];
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            quiet = (sent > n_items / 3 && sent < n_items / 2);
            if (kind < 25)
            begin
                read_req($urandom_range(1) ? FC_READ_HOLD : FC_READ_INPUT,
                    16'($urandom_range(1) ? $urandom_range(300) : $urandom),
                    16'($urandom_range(9) == 0 ? $urandom_range(130) : $urandom_range(1, 6)));
                sent += 12;
            end
            else if (kind < 45)
            begin
                send_request($urandom_range(1) ? unit_sel : UNIT_BROADCAST,
                    '{FC_WRITE_ONE, 8'($urandom_range(1)), 8'($urandom), 8'($urandom),
                      8'($urandom)});
                sent += 12;
            end
            else if (kind < 60)
            begin
                write_many_req(16'($urandom_range(3) == 0 ? $urandom : $urandom_range(260)),
                    $urandom_range(1, 4));
                sent += 20;
            end
            else if (kind < 72)
            begin
                load_word(16'($urandom_range(1) ? $urandom_range(255) : $urandom),
                    16'($urandom));
                sent += 1;
            end
            else if (kind < 85)
            begin
                p = {};
                for (int i = 0; i < $urandom_range(1, 8); i++) p.push_back(8'($urandom));
                send_request($urandom_range(3) == 0 ? 8'($urandom) : unit_sel, p);
                sent += 7 + p.size();
            end
            else
            begin
                send_byte(8'($urandom));
                sent += 1;
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        unit_sel = 8'd1;
        win_lo = 16'd0;
        win_hi = 16'hFFFF;
        in_pdu = 1'b0;
        pos_cnt = 0;
        foreach (hold_mem[i]) hold_mem[i] = '0;
        foreach (meas_mem[i]) meas_mem[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        drain();
        test_window();
        random_requests(8);
        set_reg(CFG_WRITE_LOW, 16'd100);
        set_reg(CFG_WRITE_HIGH, 16'd50);
        set_reg(CFG_UNIT_ID, 16'd7);
        random_requests(8);
        drain();
        $display("Covered %0d response frames, %0d chunks and %0d register loads.",
            frames, chunks_seen, loads);
        if (errors == 0 && chunk_q.size() == 0)
            $display("PASS modbus_tcp_request_handler_core");
        else
            $display("FAIL modbus_tcp_request_handler_core");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL modbus_tcp_request_handler_core");
        $finish;
    end
endmodule

`default_nettype wire
